### rtl/grid_density_diffusion_step_top_assert.svh
// Assertion macros used by the checker file.
`ifndef GRID_DENSITY_DIFFUSION_STEP_TOP_ASSERT_SVH
`define GRID_DENSITY_DIFFUSION_STEP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define GDDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define GDDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/gdds_pkg.sv
package gdds_pkg;

  localparam int MaxGrid = 32;
  localparam int CoordW  = 5;
  localparam int AddrW   = 3 * CoordW;
  localparam int Cells   = MaxGrid * MaxGrid * MaxGrid;
  localparam int SumW    = 19;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdTick  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [2:0] RegGridSize = 3'd0;
  localparam logic [2:0] RegRest     = 3'd1;
  localparam logic [2:0] RegDiffW    = 3'd2;
  localparam logic [2:0] RegRecovW   = 3'd3;
  localparam logic [2:0] RegDamp     = 3'd4;

  localparam logic [5:0]  GridMin  = 6'd8;
  localparam logic [5:0]  GridMax  = 6'd32;
  localparam logic [14:0] DiffWMax = 15'd16384;
  localparam logic [4:0]  DivSteps = 5'd19;

  // Neighbor codes used while gathering one cell.
  localparam logic [2:0] NbOwn = 3'd0;
  localparam logic [2:0] NbXp  = 3'd1;
  localparam logic [2:0] NbXm  = 3'd2;
  localparam logic [2:0] NbYp  = 3'd3;
  localparam logic [2:0] NbYm  = 3'd4;
  localparam logic [2:0] NbZp  = 3'd5;
  localparam logic [2:0] NbZm  = 3'd6;

  typedef struct packed {
    logic [5:0]  grid_size;
    logic [15:0] rest_density;
    logic [14:0] diffusion_weight;
    logic [15:0] recovery_weight;
    logic [15:0] damping_factor;
  } cfg_t;

  typedef struct packed {
    logic       wr_io;
    logic       rd_io;
    logic       rd_sweep;
    logic [2:0] nb;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       div_load;
    logic       div_step;
    logic       l1_en;
    logic       l2_en;
    logic       wb_en;
    logic       bank_flip;
    logic       clr_en;
    logic       out_load;
  } ctl_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic sweep_last;
    logic out_busy;
  } sts_t;

  function automatic logic [15:0] lerp_trunc(input logic [15:0] a, input logic [15:0] b,
                                             input logic [15:0] w);
    logic [15:0] diff;
    logic [31:0] prod;
    diff = (b >= a) ? (b - a) : (a - b);
    prod = diff * w;
    return (b >= a) ? (a + prod[31:16]) : (a - prod[31:16]);
  endfunction

  function automatic logic [15:0] damp_vel(input logic [15:0] raw, input logic [15:0] f);
    logic [15:0] mag;
    logic [31:0] prod;
    mag  = raw[15] ? (~raw + 16'd1) : raw;
    prod = mag * f;
    return raw[15] ? (~prod[31:16] + 16'd1) : prod[31:16];
  endfunction

endpackage

### rtl/gdds_datapath.sv
module gdds_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gdds_pkg::cfg_t       cfg_i,
  input  gdds_pkg::ctl_t       ctl_i,
  input  logic [79:0]          in_data_i,
  input  logic                 out_ready_i,
  output gdds_pkg::sts_t       sts_o,
  output logic                 out_valid_o,
  output logic [15:0]          out_density_o,
  output logic                 out_obstacle_o,
  output logic [15:0]          out_vel_x_o,
  output logic [15:0]          out_vel_y_o,
  output logic [15:0]          out_vel_z_o
);

  localparam int AW = gdds_pkg::AddrW;

  logic [15:0] dens_a   [gdds_pkg::Cells];
  logic [15:0] dens_b   [gdds_pkg::Cells];
  logic        mask_mem [gdds_pkg::Cells];
  logic [15:0] vx_mem   [gdds_pkg::Cells];
  logic [15:0] vy_mem   [gdds_pkg::Cells];
  logic [15:0] vz_mem   [gdds_pkg::Cells];

  logic [4:0]  io_x, io_y, io_z;
  logic [15:0] io_dens, io_vx, io_vy, io_vz;
  logic        io_obs;
  logic [AW-1:0] io_addr;

  assign io_x    = in_data_i[4:0];
  assign io_y    = in_data_i[9:5];
  assign io_z    = in_data_i[14:10];
  assign io_dens = in_data_i[30:15];
  assign io_obs  = in_data_i[31];
  assign io_vx   = in_data_i[47:32];
  assign io_vy   = in_data_i[63:48];
  assign io_vz   = in_data_i[79:64];
  assign io_addr = {io_z, io_y, io_x};

  // Grid size and weight saturation.
  logic [5:0]  n;
  logic [15:0] dw;
  always_comb begin
    n = cfg_i.grid_size;
    if (n < gdds_pkg::GridMin) n = gdds_pkg::GridMin;
    if (n > gdds_pkg::GridMax) n = gdds_pkg::GridMax;
    dw = {1'b0, (cfg_i.diffusion_weight > gdds_pkg::DiffWMax) ? gdds_pkg::DiffWMax
                                                               : cfg_i.diffusion_weight};
  end

  // Sweep position.
  logic [4:0] sx_q, sy_q, sz_q;
  logic       x_end, y_end, z_end;
  assign x_end = (({1'b0, sx_q} + 6'd1) == n);
  assign y_end = (({1'b0, sy_q} + 6'd1) == n);
  assign z_end = (({1'b0, sz_q} + 6'd1) == n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
    end else if (ctl_i.sweep_clr) begin
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
    end else if (ctl_i.sweep_inc) begin
      if (x_end) begin
        sx_q <= '0;
        if (y_end) begin
          sy_q <= '0;
          sz_q <= sz_q + 5'd1;
        end else begin
          sy_q <= sy_q + 5'd1;
        end
      end else begin
        sx_q <= sx_q + 5'd1;
      end
    end
  end

  logic [AW-1:0] own_addr;
  assign own_addr = {sz_q, sy_q, sx_q};

  // Neighbor address and in-bounds flag.
  logic [AW-1:0] nb_addr;
  logic          nb_inb;
  always_comb begin
    nb_addr = own_addr;
    nb_inb  = 1'b1;
    case (ctl_i.nb)
      gdds_pkg::NbOwn: begin
        nb_addr = own_addr;
        nb_inb  = 1'b1;
      end
      gdds_pkg::NbXp: begin
        nb_addr = {sz_q, sy_q, sx_q + 5'd1};
        nb_inb  = !x_end;
      end
      gdds_pkg::NbXm: begin
        nb_addr = {sz_q, sy_q, sx_q - 5'd1};
        nb_inb  = (sx_q != 5'd0);
      end
      gdds_pkg::NbYp: begin
        nb_addr = {sz_q, sy_q + 5'd1, sx_q};
        nb_inb  = !y_end;
      end
      gdds_pkg::NbYm: begin
        nb_addr = {sz_q, sy_q - 5'd1, sx_q};
        nb_inb  = (sy_q != 5'd0);
      end
      gdds_pkg::NbZp: begin
        nb_addr = {sz_q + 5'd1, sy_q, sx_q};
        nb_inb  = !z_end;
      end
      gdds_pkg::NbZm: begin
        nb_addr = {sz_q - 5'd1, sy_q, sx_q};
        nb_inb  = (sz_q != 5'd0);
      end
      default: begin
        nb_addr = own_addr;
        nb_inb  = 1'b0;
      end
    endcase
  end

  logic          rd_en;
  logic [AW-1:0] raddr;
  assign rd_en = ctl_i.rd_io | ctl_i.rd_sweep;
  assign raddr = ctl_i.rd_io ? io_addr : nb_addr;

  logic [15:0] ra_q, rb_q, rvx_q, rvy_q, rvz_q;
  logic        rmask_q;
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ra_q    <= dens_a[raddr];
      rb_q    <= dens_b[raddr];
      rmask_q <= mask_mem[raddr];
      rvx_q   <= vx_mem[raddr];
      rvy_q   <= vy_mem[raddr];
      rvz_q   <= vz_mem[raddr];
    end
  end

  logic bank_q;
  logic [15:0] rcur;
  assign rcur = bank_q ? rb_q : ra_q;

  // Clearing pass over the obstacle mask after reset.
  logic [AW-1:0] clr_q;
  assign sts_o.clr_done = &clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.clr_en) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  logic [15:0] v2_q, dvx_q, dvy_q, dvz_q;
  logic        own_blk_q;
  logic [15:0] wb_dens, wb_vx, wb_vy, wb_vz;
  assign wb_dens = own_blk_q ? 16'd0 : v2_q;
  assign wb_vx   = own_blk_q ? 16'd0 : dvx_q;
  assign wb_vy   = own_blk_q ? 16'd0 : dvy_q;
  assign wb_vz   = own_blk_q ? 16'd0 : dvz_q;

  logic [15:0] io_wdens, io_wvx, io_wvy, io_wvz;
  assign io_wdens = io_obs ? 16'd0 : io_dens;
  assign io_wvx   = io_obs ? 16'd0 : io_vx;
  assign io_wvy   = io_obs ? 16'd0 : io_vy;
  assign io_wvz   = io_obs ? 16'd0 : io_vz;

  logic [AW-1:0] waddr;
  assign waddr = ctl_i.wr_io ? io_addr : own_addr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_io || (ctl_i.wb_en && bank_q)) begin
      dens_a[waddr] <= ctl_i.wr_io ? io_wdens : wb_dens;
    end
    if (ctl_i.wr_io || (ctl_i.wb_en && !bank_q)) begin
      dens_b[waddr] <= ctl_i.wr_io ? io_wdens : wb_dens;
    end
    if (ctl_i.wr_io || ctl_i.wb_en) begin
      vx_mem[waddr] <= ctl_i.wr_io ? io_wvx : wb_vx;
      vy_mem[waddr] <= ctl_i.wr_io ? io_wvy : wb_vy;
      vz_mem[waddr] <= ctl_i.wr_io ? io_wvz : wb_vz;
    end
    if (ctl_i.clr_en || ctl_i.wr_io) begin
      mask_mem[ctl_i.clr_en ? clr_q : io_addr] <= ctl_i.clr_en ? 1'b0 : io_obs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
    end else if (ctl_i.bank_flip) begin
      bank_q <= ~bank_q;
    end
  end

  // Gather: read data arrives in the cycle after its address.
  logic       rsw_q, rinb_q;
  logic [2:0] rk_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsw_q <= 1'b0;
    end else begin
      rsw_q <= ctl_i.rd_sweep;
    end
  end

  logic [gdds_pkg::SumW-1:0] sum_q;
  logic [2:0]  cnt_q;
  logic [15:0] own_q, vx_q, vy_q, vz_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_sweep) begin
      rk_q   <= ctl_i.nb;
      rinb_q <= nb_inb;
      if (ctl_i.nb == gdds_pkg::NbOwn) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
    end
    if (rsw_q) begin
      if (rk_q == gdds_pkg::NbOwn) begin
        own_q     <= rcur;
        own_blk_q <= rmask_q;
        vx_q      <= rvx_q;
        vy_q      <= rvy_q;
        vz_q      <= rvz_q;
      end else if (rinb_q && !rmask_q) begin
        sum_q <= sum_q + {3'd0, rcur};
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // Restoring divider, one quotient bit per step.
  logic [gdds_pkg::SumW-1:0] dq_q;
  logic [2:0] dr_q;
  logic [4:0] dcnt_q;
  logic [3:0] dtrial;
  assign dtrial = {dr_q, dq_q[gdds_pkg::SumW-1]};
  assign sts_o.div_done = (dcnt_q == gdds_pkg::DivSteps);

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_load) begin
      dq_q   <= sum_q;
      dr_q   <= '0;
      dcnt_q <= '0;
    end else if (ctl_i.div_step) begin
      dcnt_q <= dcnt_q + 5'd1;
      if (dtrial >= {1'b0, cnt_q}) begin
        dr_q <= 3'(dtrial - {1'b0, cnt_q});
        dq_q <= {dq_q[gdds_pkg::SumW-2:0], 1'b1};
      end else begin
        dr_q <= dtrial[2:0];
        dq_q <= {dq_q[gdds_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  logic [15:0] avg;
  assign avg = (cnt_q == 3'd0) ? own_q : dq_q[15:0];

  logic [15:0] v1_q, v2_raw;
  assign v2_raw = gdds_pkg::lerp_trunc(v1_q, cfg_i.rest_density, cfg_i.recovery_weight);

  always_ff @(posedge clk_i) begin
    if (ctl_i.l1_en) begin
      v1_q  <= gdds_pkg::lerp_trunc(own_q, avg, dw);
      dvx_q <= gdds_pkg::damp_vel(vx_q, cfg_i.damping_factor);
      dvy_q <= gdds_pkg::damp_vel(vy_q, cfg_i.damping_factor);
      dvz_q <= gdds_pkg::damp_vel(vz_q, cfg_i.damping_factor);
    end
    if (ctl_i.l2_en) begin
      v2_q <= (v2_raw > cfg_i.rest_density) ? cfg_i.rest_density : v2_raw;
    end
  end

  assign sts_o.sweep_last = x_end && y_end && z_end;

  // Output register.
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_density_o  <= rcur;
      out_obstacle_o <= rmask_q;
      out_vel_x_o    <= rvx_q;
      out_vel_y_o    <= rvy_q;
      out_vel_z_o    <= rvz_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

endmodule

### rtl/gdds_ctrl.sv
module gdds_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     in_cmd_i,
  output logic           in_ready_o,
  input  gdds_pkg::sts_t sts_i,
  output gdds_pkg::ctl_t ctl_o
);

  localparam logic [3:0] StClear  = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StRdOut  = 4'd2;
  localparam logic [3:0] StTRead  = 4'd3;
  localparam logic [3:0] StTLast  = 4'd4;
  localparam logic [3:0] StTDLoad = 4'd5;
  localparam logic [3:0] StTDiv   = 4'd6;
  localparam logic [3:0] StTL1    = 4'd7;
  localparam logic [3:0] StTL2    = 4'd8;
  localparam logic [3:0] StTWb    = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] k_q, k_d;
  logic       accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ctl_o   = '0;
    case (state_q)
      StClear: begin
        ctl_o.clr_en = 1'b1;
        if (sts_i.clr_done) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          case (in_cmd_i)
            gdds_pkg::CmdWrite: ctl_o.wr_io = 1'b1;
            gdds_pkg::CmdTick: begin
              ctl_o.sweep_clr = 1'b1;
              k_d     = gdds_pkg::NbOwn;
              state_d = StTRead;
            end
            gdds_pkg::CmdRead: begin
              ctl_o.rd_io = 1'b1;
              state_d     = StRdOut;
            end
            default: ;
          endcase
        end
      end
      StRdOut: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StTRead: begin
        ctl_o.rd_sweep = 1'b1;
        ctl_o.nb       = k_q;
        if (k_q == gdds_pkg::NbZm) begin
          k_d     = gdds_pkg::NbOwn;
          state_d = StTLast;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      StTLast: state_d = StTDLoad;
      StTDLoad: begin
        ctl_o.div_load = 1'b1;
        state_d        = StTDiv;
      end
      StTDiv: begin
        if (sts_i.div_done) state_d = StTL1;
        else ctl_o.div_step = 1'b1;
      end
      StTL1: begin
        ctl_o.l1_en = 1'b1;
        state_d     = StTL2;
      end
      StTL2: begin
        ctl_o.l2_en = 1'b1;
        state_d     = StTWb;
      end
      StTWb: begin
        ctl_o.wb_en = 1'b1;
        if (sts_i.sweep_last) begin
          ctl_o.bank_flip = 1'b1;
          state_d         = StIdle;
        end else begin
          ctl_o.sweep_inc = 1'b1;
          state_d         = StTRead;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      k_q     <= gdds_pkg::NbOwn;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule

### rtl/grid_density_diffusion_step_top.sv
// Masked 3-D diffusion grid of up to 32x32x32 cells. After reset the block clears its
// whole obstacle mask and takes no item meanwhile; register writes work at any time.
// A cell write keeps the block ready for another item. A cell read waits in a read-out
// state while an earlier result is still stalled, and its result is held in an output
// register, where it may wait while later items are taken. A tick sweeps every cell of
// the cube in use: each cell gathers its own and six neighbor entries through the single
// read port of the cell memories, then a one-bit-per-step divider forms the neighbor
// average, followed by the two blends and the write-back. No item is taken during a tick.
module grid_density_diffusion_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_x[4:0], cell_y[9:5], cell_z[14:10], density_in[30:15], obstacle_in[31],
  // vel_x_in[47:32], vel_y_in[63:48], vel_z_in[79:64]
  input  logic [79:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // density_out[15:0], obstacle_out[16], vel_x_out[32:17], vel_y_out[48:33],
  // vel_z_out[64:49], zero[71:65]
  output logic [71:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gdds_pkg::cfg_t cfg_q;
  gdds_pkg::ctl_t ctl;
  gdds_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_size        <= 6'd32;
      cfg_q.rest_density     <= 16'd4096;
      cfg_q.diffusion_weight <= 15'd0;
      cfg_q.recovery_weight  <= 16'd0;
      cfg_q.damping_factor   <= 16'd65535;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        gdds_pkg::RegGridSize: cfg_q.grid_size        <= pwdata[5:0];
        gdds_pkg::RegRest:     cfg_q.rest_density     <= pwdata[15:0];
        gdds_pkg::RegDiffW:    cfg_q.diffusion_weight <= pwdata[14:0];
        gdds_pkg::RegRecovW:   cfg_q.recovery_weight  <= pwdata[15:0];
        gdds_pkg::RegDamp:     cfg_q.damping_factor   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      gdds_pkg::RegGridSize: prdata = {26'd0, cfg_q.grid_size};
      gdds_pkg::RegRest:     prdata = {16'd0, cfg_q.rest_density};
      gdds_pkg::RegDiffW:    prdata = {17'd0, cfg_q.diffusion_weight};
      gdds_pkg::RegRecovW:   prdata = {16'd0, cfg_q.recovery_weight};
      gdds_pkg::RegDamp:     prdata = {16'd0, cfg_q.damping_factor};
      default:               prdata = 32'd0;
    endcase
  end

  logic [15:0] o_dens, o_vx, o_vy, o_vz;
  logic        o_obs;

  gdds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  gdds_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .ctl_i          (ctl),
    .in_data_i      (s_axis_tdata),
    .out_ready_i    (m_axis_tready),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_density_o  (o_dens),
    .out_obstacle_o (o_obs),
    .out_vel_x_o    (o_vx),
    .out_vel_y_o    (o_vy),
    .out_vel_z_o    (o_vz)
  );

  assign m_axis_tdata = {7'd0, o_vz, o_vy, o_vx, o_obs, o_dens};

endmodule

### rtl/gdds_checker.sv
`include "grid_density_diffusion_step_top_assert.svh"

module gdds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // A stalled result keeps its value.
  `GDDS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The padding above the last output field stays zero.
  `GDDS_ASSERT_IMPL(a_out_pad, m_axis_tvalid, m_axis_tdata[71:65] == 7'd0)

  // A read or a tick keeps the input side closed in the following cycle.
  `GDDS_ASSERT_NEXT(a_read_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == gdds_pkg::CmdRead, !s_axis_tready)

  `GDDS_ASSERT_NEXT(a_tick_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser == gdds_pkg::CmdTick, !s_axis_tready)

endmodule

bind grid_density_diffusion_step_top gdds_checker u_checker (.*);

### bench/grid_density_diffusion_step_top_tb.sv
`timescale 1ns / 1ps

module grid_density_diffusion_step_top_tb;

  typedef struct packed {
    logic [15:0] density;
    logic        obstacle;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] vel_z;
  } cell_view_t;

  localparam int StallLimit = 200000;
  localparam logic [1:0] CmdUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_density_diffusion_step_top uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of the grid and the registers.
  logic [15:0] dens_a [gdds_pkg::Cells];
  logic [15:0] dens_b [gdds_pkg::Cells];
  logic        blocked [gdds_pkg::Cells];
  logic [15:0] vel_xs [gdds_pkg::Cells];
  logic [15:0] vel_ys [gdds_pkg::Cells];
  logic [15:0] vel_zs [gdds_pkg::Cells];
  logic        bank_sel;
  int          written_cells [$];
  bit          is_written [gdds_pkg::Cells];
  logic [5:0]  cfg_grid = 6'd32;
  logic [15:0] cfg_rest = 16'd4096;
  logic [14:0] cfg_diff = '0;
  logic [15:0] cfg_recov = '0;
  logic [15:0] cfg_damp = 16'hFFFF;

  cell_view_t  pending_reads [$];
  int          fail_count = 0;
  int          reads_checked = 0;
  int          ticks_sent = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          quiet_cycles = 0;

  function automatic int cell_index(int x, int y, int z);
    return x + y * gdds_pkg::MaxGrid + z * gdds_pkg::MaxGrid * gdds_pkg::MaxGrid;
  endfunction

  function automatic logic [15:0] blend_toward(logic [15:0] a, logic [15:0] b, logic [15:0] w);
    longint unsigned step;
    if (b >= a) begin
      step = (longint'(b - a) * w) >> 16;
      return a + step[15:0];
    end
    step = (longint'(a - b) * w) >> 16;
    return a - step[15:0];
  endfunction

  function automatic logic [15:0] damp_velocity(logic [15:0] raw, logic [15:0] f);
    longint unsigned mag;
    longint unsigned prod;
    if (raw[15]) begin
      mag = 65536 - raw;
      prod = (mag * f) >> 16;
      return 16'(65536 - prod);
    end
    prod = (longint'(raw) * f) >> 16;
    return prod[15:0];
  endfunction

  task automatic advance_density_field();
    int n;
    int i;
    int sum;
    int cnt;
    int j;
    logic [15:0] own;
    logic [15:0] avg;
    logic [15:0] v;
    logic [15:0] dw;
    logic [15:0] cur [gdds_pkg::Cells];
    n = (cfg_grid < 8) ? 8 : (cfg_grid > gdds_pkg::MaxGrid) ? gdds_pkg::MaxGrid
                                                              : int'(cfg_grid);
    dw = (cfg_diff > gdds_pkg::DiffWMax) ? 16'(gdds_pkg::DiffWMax) : 16'(cfg_diff);
    cur = bank_sel ? dens_b : dens_a;
    for (int z = 0; z < n; z++)
      for (int y = 0; y < n; y++)
        for (int x = 0; x < n; x++) begin
          i = cell_index(x, y, z);
          if (blocked[i]) begin
            if (bank_sel) dens_a[i] = '0; else dens_b[i] = '0;
            vel_xs[i] = '0;
            vel_ys[i] = '0;
            vel_zs[i] = '0;
            continue;
          end
          sum = 0;
          cnt = 0;
          for (int k = 0; k < 6; k++) begin
            int nx, ny, nz;
            nx = x + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
            ny = y + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
            nz = z + ((k == 4) ? 1 : (k == 5) ? -1 : 0);
            if (nx < 0 || ny < 0 || nz < 0 || nx >= n || ny >= n || nz >= n) continue;
            j = cell_index(nx, ny, nz);
            if (blocked[j]) continue;
            sum += cur[j];
            cnt++;
          end
          own = cur[i];
          avg = cnt ? 16'(sum / cnt) : own;
          v = blend_toward(own, avg, dw);
          v = blend_toward(v, cfg_rest, cfg_recov);
          if (v > cfg_rest) v = cfg_rest;
          if (bank_sel) dens_a[i] = v; else dens_b[i] = v;
          vel_xs[i] = damp_velocity(vel_xs[i], cfg_damp);
          vel_ys[i] = damp_velocity(vel_ys[i], cfg_damp);
          vel_zs[i] = damp_velocity(vel_zs[i], cfg_damp);
        end
    bank_sel = ~bank_sel;
  endtask

  task automatic apply_cell_item(logic [1:0] cmd, int x, int y, int z, logic [15:0] d,
                                 logic o, logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    int i;
    cell_view_t r;
    i = cell_index(x, y, z);
    case (cmd)
      gdds_pkg::CmdWrite: begin
        dens_a[i] = o ? 16'd0 : d;
        dens_b[i] = o ? 16'd0 : d;
        blocked[i] = o;
        vel_xs[i] = o ? 16'd0 : vx;
        vel_ys[i] = o ? 16'd0 : vy;
        vel_zs[i] = o ? 16'd0 : vz;
        if (!is_written[i]) begin
          is_written[i] = 1'b1;
          written_cells.push_back(i);
        end
      end
      gdds_pkg::CmdTick: begin
        advance_density_field();
        ticks_sent++;
      end
      gdds_pkg::CmdRead: begin
        r.density = bank_sel ? dens_b[i] : dens_a[i];
        r.obstacle = blocked[i];
        r.vel_x = vel_xs[i];
        r.vel_y = vel_ys[i];
        r.vel_z = vel_zs[i];
        pending_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Leaves tvalid high after acceptance so back-to-back items need no extra edge.
  task automatic push_cell_item(logic [1:0] cmd, int x, int y, int z, logic [15:0] d = '0,
                                logic o = 1'b0, logic [15:0] vx = '0, logic [15:0] vy = '0,
                                logic [15:0] vz = '0);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {vz, vy, vx, o, d, 5'(z), 5'(y), 5'(x)};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_cell_item(cmd, x, y, z, d, o, vx, vy, vz);
  endtask

  task automatic read_known_cell();
    int i;
    i = written_cells[$urandom_range(written_cells.size() - 1)];
    push_cell_item(gdds_pkg::CmdRead, i % 32, (i / 32) % 32, i / 1024);
  endtask

  task automatic write_random_cell(int x, int y, int z);
    push_cell_item(gdds_pkg::CmdWrite, x, y, z, 16'($urandom), $urandom_range(7) == 0,
                   16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // A tick gives no result, so the block may still be sweeping once the queue drains.
  task automatic wait_until_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic set_register(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      gdds_pkg::RegGridSize: cfg_grid = value[5:0];
      gdds_pkg::RegRest:     cfg_rest = value[15:0];
      gdds_pkg::RegDiffW:    cfg_diff = value[14:0];
      gdds_pkg::RegRecovW:   cfg_recov = value[15:0];
      gdds_pkg::RegDamp:     cfg_damp = value[15:0];
      default: ;
    endcase
  endtask

  task automatic test_cell_extremes();
    push_cell_item(gdds_pkg::CmdWrite, 0, 0, 0, 16'hFFFF, 1'b0, 16'h8000, 16'h7FFF, 16'hFFFF);
    push_cell_item(gdds_pkg::CmdWrite, 31, 31, 31, 16'h0000, 1'b0, 16'h7FFF, 16'h8000,
                   16'h0001);
    push_cell_item(gdds_pkg::CmdWrite, 31, 0, 17, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA,
                   16'h1234);
    push_cell_item(gdds_pkg::CmdWrite, 0, 31, 10, 16'h5555, 1'b0, 16'hAAAA, 16'h5555,
                   16'hEDCB);
    push_cell_item(gdds_pkg::CmdRead, 0, 0, 0);
    push_cell_item(gdds_pkg::CmdRead, 31, 31, 31);
    push_cell_item(gdds_pkg::CmdRead, 31, 0, 17);
    push_cell_item(gdds_pkg::CmdRead, 0, 31, 10);
    // The unused command must be swallowed without a result.
    push_cell_item(CmdUnused, 5, 6, 7, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_cell_item(gdds_pkg::CmdWrite, 0, 0, 0, 16'h1000, 1'b1, 16'h0100, 16'h0100, 16'h0100);
    push_cell_item(gdds_pkg::CmdRead, 0, 0, 0);
    push_cell_item(gdds_pkg::CmdRead, 31, 31, 31);
  endtask

  // Every cell that a tick can touch must hold a value before the first tick.
  task automatic test_fill_cube();
    for (int z = 0; z < 8; z++)
      for (int y = 0; y < 8; y++)
        for (int x = 0; x < 8; x++) begin
          write_random_cell(x, y, z);
          if ($urandom_range(15) == 0) read_known_cell();
        end
  endtask

  task automatic test_register_settings();
    logic [31:0] settings [6][5] = '{
      '{0, 4096, 0, 0, 65535},
      '{8, 65535, 32767, 0, 0},
      '{63, 0, 16384, 65535, 32768},
      '{9, 8192, 16385, 12000, 40000},
      '{8, 20000, 8000, 3000, 65535},
      '{8, 65535, 16384, 0, 1}
    };
    for (int s = 0; s < 6; s++) begin
      wait_until_idle();
      for (int r = 0; r < 5; r++) set_register(3'(r), settings[s][r]);
      // Grid sizes above 8 are only written; the ticks then run on an 8x8x8 cube.
      if (cfg_grid > 8) set_register(gdds_pkg::RegGridSize, 8);
      push_cell_item(gdds_pkg::CmdTick, 0, 0, 0);
      repeat (4) read_known_cell();
      push_cell_item(gdds_pkg::CmdTick, 0, 0, 0);
      repeat (4) read_known_cell();
    end
  endtask

  task automatic test_random_items(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        if ($urandom_range(1)) write_random_cell($urandom_range(7), $urandom_range(7),
                                                 $urandom_range(7));
        else write_random_cell($urandom_range(31), $urandom_range(31), $urandom_range(31));
      end else if (pick < 94) begin
        read_known_cell();
      end else if (pick < 97) begin
        push_cell_item(gdds_pkg::CmdTick, 0, 0, 0);
      end else begin
        push_cell_item(CmdUnused, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                       16'($urandom), 1'($urandom), 16'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    cell_view_t want;
    cell_view_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[32:17],
               m_axis_tdata[48:33], m_axis_tdata[64:49]};
        if (pending_reads.size() == 0) begin
          $error("read result with nothing outstanding: %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_reads.pop_front();
          reads_checked++;
          if (got.density !== want.density) begin
            $error("density_out expected %h got %h", want.density, got.density);
            fail_count++;
          end
          if (got.obstacle !== want.obstacle) begin
            $error("obstacle_out expected %h got %h", want.obstacle, got.obstacle);
            fail_count++;
          end
          if (got.vel_x !== want.vel_x) begin
            $error("vel_x_out expected %h got %h", want.vel_x, got.vel_x);
            fail_count++;
          end
          if (got.vel_y !== want.vel_y) begin
            $error("vel_y_out expected %h got %h", want.vel_y, got.vel_y);
            fail_count++;
          end
          if (got.vel_z !== want.vel_z) begin
            $error("vel_z_out expected %h got %h", want.vel_z, got.vel_z);
            fail_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < gdds_pkg::Cells; i++) begin
      dens_a[i] = '0;
      dens_b[i] = '0;
      blocked[i] = 1'b0;
      vel_xs[i] = '0;
      vel_ys[i] = '0;
      vel_zs[i] = '0;
    end
    bank_sel = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 24;
    rx_idle_pct = 70;
    test_cell_extremes();
    test_fill_cube();
    tx_idle_pct = 70;
    rx_idle_pct = 24;
    test_register_settings();
    test_random_items(150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_items(250);
    s_axis_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Covered cell writes with obstacles, %0d ticks over six register settings,",
             ticks_sent);
    $display("and %0d checked cell reads under three idling patterns.", reads_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### grid_density_diffusion_step_top.f
+incdir+rtl
rtl/gdds_pkg.sv
rtl/gdds_datapath.sv
rtl/gdds_ctrl.sv
rtl/grid_density_diffusion_step_top.sv
rtl/gdds_checker.sv
bench/grid_density_diffusion_step_top_tb.sv
